// File: design/gzp_pkg.sv
package gzp_pkg;

  // apb register indexes, byte address is 4*index
  localparam logic REG_PLACE_DISTANCE = 1'b0;
  localparam logic REG_MIN_DISTANCE   = 1'b1;

  localparam logic [31:0] PLACE_DISTANCE_RST = 32'd85197;
  localparam logic [31:0] MIN_DISTANCE_RST   = 32'd0;

  localparam int DIR_BITS = 30;

  typedef struct packed {
    logic signed [31:0] head_x;
    logic signed [31:0] head_y;
    logic signed [31:0] head_z;
    logic signed [31:0] fwd_x;
    logic signed [31:0] fwd_y;
    logic signed [31:0] fwd_z;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic               has_hit;
  } in_t;

  typedef struct packed {
    logic signed [31:0] place_x;
    logic signed [31:0] place_y;
    logic signed [31:0] place_z;
    logic        [30:0] place_dist;
  } out_t;

  // item context while the forward length is taken
  typedef struct packed {
    logic [2:0][31:0] head;
    logic [2:0][31:0] hit;
    logic             has_hit;
    logic [2:0][31:0] fmag;
    logic [2:0]       fneg;
  } fctx_t;

  // item context through the direction divide
  typedef struct packed {
    logic [2:0][31:0] head;
    logic [2:0][31:0] hit;
    logic             has_hit;
    logic [2:0]       fneg;
    logic             tiny;
  } dctx_t;

  // item context through the distance root
  typedef struct packed {
    logic [2:0][33:0] p;
    logic [2:0][33:0] pp;
    logic             push;
    logic             far;
  } pctx_t;

endpackage

// File: design/gaze_ray_place_point.sv
// gaze_ray_place_point: places a point along a gaze ray in signed fixed point
// throughput: one item per cycle, busy is never raised, the result is never held off
// latency is set by two 32-step square root pipelines and a 31-step divide pipeline
// reset (rst_n, synchronous, active low) clears all valid bits and loads register resets
module gaze_ray_place_point #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gzp_pkg::in_t        in_data,
  output logic                out_valid,
  output gzp_pkg::out_t       out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import gzp_pkg::*;

  // forward lengths at or below 1e-6 in squared form
  localparam logic [63:0] THR = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000000000;
  // 1.3 metres
  localparam logic [63:0] FALLBACK = ((64'd13 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam logic [30:0] DIR_ONE = 31'(64'd1 << DIR_BITS);
  localparam logic [61:0] RND = 62'(64'd1 << (DIR_BITS - 1));

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [31:0] place_r;
  logic [31:0] min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      place_r <= PLACE_DISTANCE_RST;
      min_r   <= MIN_DISTANCE_RST;
    end else if (psel && penable && pwrite) begin
      // byte lane bits are not decoded
      if (paddr[2] == REG_MIN_DISTANCE) begin
        min_r <= pwdata;
      end else begin
        place_r <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_MIN_DISTANCE) ? min_r : place_r;
  assign pready = 1'b1;
  assign busy   = 1'b0;

  // negative minimum counts as zero
  logic [30:0] min_d;
  logic [30:0] proj_d;
  logic [30:0] fb_d;

  assign min_d = min_r[31] ? 31'd0 : min_r[30:0];
  assign fb_d  = (min_d > FALLBACK[30:0]) ? min_d : FALLBACK[30:0];
  // non-positive projection distance falls back to max(min, 1.3)
  assign proj_d = (!place_r[31] && (place_r != 32'd0)) ? place_r[30:0] : fb_d;

  // ---------------------------------------------------------------------------
  // input register, then squares of the forward components
  // ---------------------------------------------------------------------------
  logic  in_v_r;
  in_t   in_r;
  fctx_t in_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  always_comb begin
    in_c.head    = {in_r.head_x, in_r.head_y, in_r.head_z};
    in_c.hit     = {in_r.hit_x, in_r.hit_y, in_r.hit_z};
    in_c.has_hit = in_r.has_hit;
    in_c.fneg    = {in_r.fwd_x[31], in_r.fwd_y[31], in_r.fwd_z[31]};
    in_c.fmag[2] = in_r.fwd_x[31] ? 32'(-in_r.fwd_x) : 32'(in_r.fwd_x);
    in_c.fmag[1] = in_r.fwd_y[31] ? 32'(-in_r.fwd_y) : 32'(in_r.fwd_y);
    in_c.fmag[0] = in_r.fwd_z[31] ? 32'(-in_r.fwd_z) : 32'(in_r.fwd_z);
  end

  logic             sq_v_r;
  logic [2:0][63:0] sq_r;
  fctx_t            sq_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else begin
      sq_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= 64'(in_c.fmag[i]) * 64'(in_c.fmag[i]);
    end
    sq_c_r <= in_c;
  end

  // ---------------------------------------------------------------------------
  // squared length, then floor square root, one result bit per stage
  // ---------------------------------------------------------------------------
  logic        sqa_v_r   [0:32];
  logic [63:0] sqa_n_r   [0:32];
  logic [63:0] sqa_res_r [0:32];
  fctx_t       sqa_c_r   [0:32];
  logic        sqa_t_r   [0:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqa_v_r[0] <= 1'b0;
    end else begin
      sqa_v_r[0] <= sq_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sqa_n_r[0]   <= sq_r[0] + sq_r[1] + sq_r[2];
    sqa_t_r[0]   <= (sq_r[0] + sq_r[1] + sq_r[2]) <= THR;
    sqa_res_r[0] <= 64'd0;
    sqa_c_r[0]   <= sq_c_r;
  end

  for (genvar k = 0; k < 32; k++) begin : g_sqa
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;

    assign trial = sqa_res_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqa_v_r[k+1] <= 1'b0;
      end else begin
        sqa_v_r[k+1] <= sqa_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (sqa_n_r[k] >= trial) begin
        sqa_n_r[k+1]   <= sqa_n_r[k] - trial;
        sqa_res_r[k+1] <= (sqa_res_r[k] >> 1) + BIT;
      end else begin
        sqa_n_r[k+1]   <= sqa_n_r[k];
        sqa_res_r[k+1] <= sqa_res_r[k] >> 1;
      end
      sqa_c_r[k+1] <= sqa_c_r[k];
      sqa_t_r[k+1] <= sqa_t_r[k];
    end
  end

  // ---------------------------------------------------------------------------
  // direction divide: (mag << 30 + len/2) / len, one quotient bit per stage
  // ---------------------------------------------------------------------------
  logic             dv_v_r   [0:31];
  logic [2:0][63:0] dv_rem_r [0:31];
  logic [2:0][30:0] dv_q_r   [0:31];
  logic [31:0]      dv_len_r [0:31];
  dctx_t            dv_c_r   [0:31];
  logic [31:0]      len_a;

  // a tiny forward takes the fixed direction, so its divisor only has to be nonzero
  assign len_a = sqa_t_r[32] ? 32'd1 : sqa_res_r[32][31:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= sqa_v_r[32];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= (64'(sqa_c_r[32].fmag[i]) << DIR_BITS) + 64'(len_a >> 1);
    end
    dv_q_r[0]          <= '0;
    dv_len_r[0]        <= len_a;
    dv_c_r[0].head     <= sqa_c_r[32].head;
    dv_c_r[0].hit      <= sqa_c_r[32].hit;
    dv_c_r[0].has_hit  <= sqa_c_r[32].has_hit;
    dv_c_r[0].fneg     <= sqa_c_r[32].fneg;
    dv_c_r[0].tiny     <= sqa_t_r[32];
  end

  for (genvar j = 0; j < 31; j++) begin : g_div
    logic [63:0] dsor;

    assign dsor = 64'(dv_len_r[j]) << (30 - j);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j+1] <= 1'b0;
      end else begin
        dv_v_r[j+1] <= dv_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[j][i] >= dsor) begin
          dv_rem_r[j+1][i] <= dv_rem_r[j][i] - dsor;
          dv_q_r[j+1][i]   <= {dv_q_r[j][i][29:0], 1'b1};
        end else begin
          dv_rem_r[j+1][i] <= dv_rem_r[j][i];
          dv_q_r[j+1][i]   <= {dv_q_r[j][i][29:0], 1'b0};
        end
      end
      dv_len_r[j+1] <= dv_len_r[j];
      dv_c_r[j+1]   <= dv_c_r[j];
    end
  end

  // ---------------------------------------------------------------------------
  // unit direction as sign and Q1.30 magnitude
  // ---------------------------------------------------------------------------
  logic             dr_v_r;
  logic [2:0][30:0] dr_m_r;
  logic [2:0]       dr_neg_r;
  dctx_t            dr_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dr_v_r <= 1'b0;
    end else begin
      dr_v_r <= dv_v_r[31];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_c_r[31].tiny) begin
        // negligible forward looks along -z, z is lane 0
        dr_m_r[i]   <= (i == 0) ? DIR_ONE : 31'd0;
        dr_neg_r[i] <= (i == 0);
      end else begin
        dr_m_r[i]   <= (dv_q_r[31][i] > DIR_ONE) ? DIR_ONE : dv_q_r[31][i];
        dr_neg_r[i] <= dv_c_r[31].fneg[i];
      end
    end
    dr_c_r <= dv_c_r[31];
  end

  // ---------------------------------------------------------------------------
  // offsets along the ray for the projection and the minimum distance
  // ---------------------------------------------------------------------------
  logic             m1_v_r;
  logic [2:0][61:0] m1_pp_r;
  logic [2:0][61:0] m1_pm_r;
  logic [2:0]       m1_neg_r;
  dctx_t            m1_c_r;
  logic [61:0]      m1_msq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else begin
      m1_v_r <= dr_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      m1_pp_r[i] <= 62'(dr_m_r[i]) * 62'(proj_d);
      m1_pm_r[i] <= 62'(dr_m_r[i]) * 62'(min_d);
    end
    m1_msq_r <= 62'(min_d) * 62'(min_d);
    m1_neg_r <= dr_neg_r;
    m1_c_r   <= dr_c_r;
  end

  logic                    m2_v_r;
  logic signed [2:0][33:0] m2_p_r;
  logic signed [2:0][33:0] m2_pp_r;
  logic        [2:0][31:0] m2_head_r;
  logic        [61:0]      m2_msq_r;
  logic        [2:0][31:0] offp;
  logic        [2:0][31:0] offm;
  logic signed [2:0][33:0] hd34;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      offp[i] = 32'((m1_pp_r[i] + RND) >> DIR_BITS);
      offm[i] = 32'((m1_pm_r[i] + RND) >> DIR_BITS);
      hd34[i] = 34'(signed'(m1_c_r.head[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else begin
      m2_v_r <= m1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (m1_c_r.has_hit) begin
        m2_p_r[i] <= 34'(signed'(m1_c_r.hit[i]));
      end else if (m1_neg_r[i]) begin
        m2_p_r[i] <= hd34[i] - 34'(offp[i]);
      end else begin
        m2_p_r[i] <= hd34[i] + 34'(offp[i]);
      end
      m2_pp_r[i] <= m1_neg_r[i] ? (hd34[i] - 34'(offm[i])) : (hd34[i] + 34'(offm[i]));
    end
    m2_head_r <= m1_c_r.head;
    m2_msq_r  <= m1_msq_r;
  end

  // ---------------------------------------------------------------------------
  // squared distance from the head and the far test
  // ---------------------------------------------------------------------------
  logic                    d1_v_r;
  logic        [2:0][30:0] d1_m_r;
  logic                    d1_far_r;
  logic signed [2:0][33:0] d1_p_r;
  logic signed [2:0][33:0] d1_pp_r;
  logic        [61:0]      d1_msq_r;
  logic signed [2:0][34:0] diff;
  logic        [2:0][34:0] dmag;
  logic                    far_c;

  always_comb begin
    far_c = 1'b0;
    for (int i = 0; i < 3; i++) begin
      // packed elements are unsigned, so sign them before widening
      diff[i] = 35'(signed'(m2_p_r[i])) - 35'(signed'(m2_head_r[i]));
      dmag[i] = diff[i][34] ? 35'(-diff[i]) : 35'(diff[i]);
      far_c   = far_c | (|dmag[i][34:31]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
    end else begin
      d1_v_r <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d1_m_r[i] <= dmag[i][30:0];
    end
    d1_far_r <= far_c;
    d1_p_r   <= m2_p_r;
    d1_pp_r  <= m2_pp_r;
    d1_msq_r <= m2_msq_r;
  end

  logic             d2_v_r;
  logic [2:0][61:0] d2_sq_r;
  pctx_t            d2_c_r;
  logic [61:0]      d2_msq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v_r <= 1'b0;
    end else begin
      d2_v_r <= d1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d2_sq_r[i] <= 62'(d1_m_r[i]) * 62'(d1_m_r[i]);
    end
    d2_c_r.p    <= d1_p_r;
    d2_c_r.pp   <= d1_pp_r;
    d2_c_r.far  <= d1_far_r;
    d2_c_r.push <= 1'b0;
    d2_msq_r    <= d1_msq_r;
  end

  // ---------------------------------------------------------------------------
  // distance root, one result bit per stage, remainder kept for rounding
  // ---------------------------------------------------------------------------
  logic        sqb_v_r   [0:32];
  logic [63:0] sqb_n_r   [0:32];
  logic [63:0] sqb_res_r [0:32];
  pctx_t       sqb_c_r   [0:32];
  logic [63:0] sd;

  assign sd = 64'(d2_sq_r[0]) + 64'(d2_sq_r[1]) + 64'(d2_sq_r[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqb_v_r[0] <= 1'b0;
    end else begin
      sqb_v_r[0] <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    sqb_n_r[0]        <= sd;
    sqb_res_r[0]      <= 64'd0;
    sqb_c_r[0].p      <= d2_c_r.p;
    sqb_c_r[0].pp     <= d2_c_r.pp;
    sqb_c_r[0].far    <= d2_c_r.far;
    // exact inside-sphere test on squared values
    sqb_c_r[0].push   <= !d2_c_r.far && (sd < 64'(d2_msq_r));
  end

  for (genvar k = 0; k < 32; k++) begin : g_sqb
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] trial;

    assign trial = sqb_res_r[k] + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sqb_v_r[k+1] <= 1'b0;
      end else begin
        sqb_v_r[k+1] <= sqb_v_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (sqb_n_r[k] >= trial) begin
        sqb_n_r[k+1]   <= sqb_n_r[k] - trial;
        sqb_res_r[k+1] <= (sqb_res_r[k] >> 1) + BIT;
      end else begin
        sqb_n_r[k+1]   <= sqb_n_r[k];
        sqb_res_r[k+1] <= sqb_res_r[k] >> 1;
      end
      sqb_c_r[k+1] <= sqb_c_r[k];
    end
  end

  // ---------------------------------------------------------------------------
  // rounding, point select, saturation, result register
  // ---------------------------------------------------------------------------
  logic                    out_valid_r;
  out_t                    out_data_r;
  logic        [63:0]      dist_rnd;
  logic        [30:0]      dist_sel;
  logic signed [2:0][33:0] pt;
  logic        [2:0][31:0] pt_sat;

  always_comb begin
    // remainder above the root means the value lies past the half step
    dist_rnd = (sqb_n_r[32] > sqb_res_r[32]) ? (sqb_res_r[32] + 64'd1) : sqb_res_r[32];
    if (sqb_c_r[32].push) begin
      dist_sel = min_d;
    end else if (sqb_c_r[32].far || (dist_rnd > 64'h7FFF_FFFF)) begin
      dist_sel = 31'h7FFF_FFFF;
    end else begin
      dist_sel = dist_rnd[30:0];
    end
    for (int i = 0; i < 3; i++) begin
      pt[i] = sqb_c_r[32].push ? sqb_c_r[32].pp[i] : sqb_c_r[32].p[i];
      if (signed'(pt[i]) > 34'sh0_7FFF_FFFF) begin
        pt_sat[i] = 32'h7FFF_FFFF;
      end else if (signed'(pt[i]) < -34'sh0_8000_0000) begin
        pt_sat[i] = 32'h8000_0000;
      end else begin
        pt_sat[i] = pt[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= sqb_v_r[32];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.place_x    <= pt_sat[2];
    out_data_r.place_y    <= pt_sat[1];
    out_data_r.place_z    <= pt_sat[0];
    out_data_r.place_dist <= dist_sel;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // floor root leaves a remainder of at most twice the root
  a_len_rem : assert property (@(posedge clk) disable iff (!rst_n)
    sqa_v_r[32] |-> (sqa_n_r[32] <= (sqa_res_r[32] << 1)))
    else $error("length root remainder out of range");

  // a component never exceeds the unit length before the clamp
  a_dir_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (dv_v_r[31] && !dv_c_r[31].tiny) |->
      ((dv_q_r[31][0] <= DIR_ONE) && (dv_q_r[31][1] <= DIR_ONE) &&
       (dv_q_r[31][2] <= DIR_ONE)))
    else $error("direction component above one");

  // a pushed point reports exactly the minimum distance
  a_push_dist : assert property (@(posedge clk) disable iff (!rst_n)
    (sqb_v_r[32] && sqb_c_r[32].push) |=>
      (out_valid_r && (out_data_r.place_dist == min_d)))
    else $error("pushed point distance mismatch");

  // a far point is never pushed and saturates its distance
  a_far_sat : assert property (@(posedge clk) disable iff (!rst_n)
    (sqb_v_r[32] && sqb_c_r[32].far) |=>
      (out_valid_r && (out_data_r.place_dist == 31'h7FFF_FFFF)))
    else $error("far point distance not saturated");

endmodule
